@@ hdl/frsc_pkg.sv @@
`default_nettype none

package frsc_pkg;

    localparam logic [7:0] PREAMBLE_RESET  = 8'h55;
    localparam logic [7:0] START_MK_RESET  = 8'h7E;
    localparam logic [7:0] END_MK_RESET    = 8'h7E;
    localparam logic [7:0] MAX_LEN_RESET   = 8'h40;

    localparam logic [7:0] TYPE_START = 8'd1;
    localparam logic [7:0] TYPE_DATA  = 8'd2;
    localparam logic [7:0] TYPE_END   = 8'd3;
    localparam logic [7:0] TYPE_NACK  = 8'd4;

    localparam logic [2:0] REG_PREAMBLE  = 3'd0;
    localparam logic [2:0] REG_START_MK  = 3'd1;
    localparam logic [2:0] REG_END_MK    = 3'd2;
    localparam logic [2:0] REG_MAX_LEN   = 3'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        V_ACCEPT = 2'd0,
        V_NACK   = 2'd1,
        V_REJECT = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        E_OK      = 3'd0,
        E_CRC     = 3'd1,
        E_SEQ     = 3'd2,
        E_LEN     = 3'd3,
        E_TYPE    = 3'd4,
        E_NOSTART = 3'd5,
        E_END     = 3'd6,
        E_VALUE   = 3'd7
    } err_t;

    typedef enum logic [2:0] {
        K_BAD   = 3'd0,
        K_START = 3'd1,
        K_DATA  = 3'd2,
        K_END   = 3'd3,
        K_NACK  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] preamble;
        logic [7:0] start_mk;
        logic [7:0] end_mk;
        logic [7:0] max_len;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        err_t       code;
        logic [7:0] seq;
        logic [7:0] param;
        logic       hit;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/frsc_front.sv @@
`default_nettype none

module frsc_front (
    input  wire frsc_pkg::cfg_t  cfg,
    input  wire logic [7:0]      preamble_byte,
    input  wire logic [7:0]      start_byte,
    input  wire logic [7:0]      end_byte,
    input  wire logic [7:0]      frame_type,
    input  wire logic [7:0]      seq_num,
    input  wire logic [7:0]      payload_len,
    input  wire logic [7:0]      header_param,
    input  wire logic            crc_ok,
    input  wire logic            history_hit,
    output frsc_pkg::item_t      item
);
    import frsc_pkg::*;

    logic type_ok;

    assign type_ok = (frame_type >= TYPE_START) && (frame_type <= TYPE_NACK);

    // Format checks in priority order; a failed header carries its first error.
    always_comb
    begin
        item.seq   = seq_num;
        item.param = header_param;
        item.hit   = history_hit;
        item.kind  = K_BAD;
        item.code  = E_OK;
        if (preamble_byte != cfg.preamble || start_byte != cfg.start_mk ||
            end_byte != cfg.end_mk)
        begin
            item.code = E_VALUE;
        end
        else if (payload_len > cfg.max_len)
        begin
            item.code = E_LEN;
        end
        else if (!type_ok)
        begin
            item.code = E_TYPE;
        end
        else if (frame_type != TYPE_DATA && payload_len != 8'd0)
        begin
            item.code = E_LEN;
        end
        else if (!crc_ok)
        begin
            item.code = E_CRC;
        end
        else
        begin
            case (frame_type)
                TYPE_START: item.kind = K_START;
                TYPE_DATA:  item.kind = K_DATA;
                TYPE_END:   item.kind = K_END;
                TYPE_NACK:  item.kind = K_NACK;
                default:    item.kind = K_BAD;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/frsc_queue.sv @@
`default_nettype none

module frsc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire frsc_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output frsc_pkg::item_t      head
);
    import frsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/frsc_back.sv @@
`default_nettype none

module frsc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire frsc_pkg::item_t item,
    output logic                 item_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           verdict,
    output logic [2:0]           error_code,
    output logic [7:0]           nack_seq,
    output logic                 retransmit_request,
    output logic [7:0]           retransmit_seq
);
    import frsc_pkg::*;

    logic        session_reg, session_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  next_seq_reg, next_seq_next;
    logic        out_valid_reg, out_valid_next;
    verdict_t    verdict_reg, verdict_next;
    err_t        code_reg, code_next;
    logic [7:0]  nack_seq_reg, nack_seq_next;
    logic        rreq_reg, rreq_next;
    logic [7:0]  rseq_reg, rseq_next;

    assign item_pop = item_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        session_next  = session_reg;
        total_next    = total_reg;
        next_seq_next = next_seq_reg;
        verdict_next  = V_REJECT;
        code_next     = item.code;
        nack_seq_next = 8'd0;
        rreq_next     = 1'b0;
        rseq_next     = 8'd0;
        case (item.kind)
            K_START:
            begin
                if (item.seq != 8'd0)
                begin
                    code_next = E_SEQ;
                end
                else
                begin
                    session_next  = 1'b1;
                    total_next    = item.param;
                    next_seq_next = 8'd1;
                    verdict_next  = V_ACCEPT;
                end
            end
            K_DATA, K_END:
            begin
                if (!session_reg)
                begin
                    code_next = E_NOSTART;
                end
                else if (item.seq != next_seq_reg)
                begin
                    code_next     = E_SEQ;
                    verdict_next  = V_NACK;
                    nack_seq_next = next_seq_reg;
                end
                else if (item.kind == K_DATA)
                begin
                    next_seq_next = next_seq_reg + 8'd1;
                    verdict_next  = V_ACCEPT;
                end
                else if (total_reg != 8'd0 && item.seq != total_reg - 8'd1)
                begin
                    code_next = E_END;
                end
                else
                begin
                    // close the session
                    session_next  = 1'b0;
                    total_next    = 8'd0;
                    next_seq_next = 8'd0;
                    verdict_next  = V_ACCEPT;
                end
            end
            K_NACK:
            begin
                rreq_next = 1'b1;
                rseq_next = item.param;
                if (item.hit)
                begin
                    verdict_next = V_ACCEPT;
                end
                else
                begin
                    code_next = E_VALUE;
                end
            end
            default:
            begin
                verdict_next = V_REJECT;
            end
        endcase

        if (item_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= 1'b0;
            total_reg     <= 8'd0;
            next_seq_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_pop)
            begin
                session_reg  <= session_next;
                total_reg    <= total_next;
                next_seq_reg <= next_seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            verdict_reg  <= verdict_next;
            code_reg     <= code_next;
            nack_seq_reg <= nack_seq_next;
            rreq_reg     <= rreq_next;
            rseq_reg     <= rseq_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign verdict            = verdict_reg;
    assign error_code         = code_reg;
    assign nack_seq           = nack_seq_reg;
    assign retransmit_request = rreq_reg;
    assign retransmit_seq     = rseq_reg;

endmodule

`default_nettype wire

@@ hdl/frame_receive_sequence_checker.sv @@
`default_nettype none

// Frame receive sequence checker: takes one frame header per beat and returns one
// verdict beat for it. A header is accepted every cycle as long as the two-entry
// queue between the format classifier and the session stage has room. Its verdict
// passes through the queue and then the output register before it is offered.
// The session stage retires one beat per cycle whenever the output register is
// free or being taken. While the output is held, two more headers fill the queue
// and in_ready drops. Marker bytes and the payload limit come from four write-only
// registers (index 0 preamble, 1 start marker, 2 end marker, 3 max payload; other
// indexes are ignored), to be written while idle.
module frame_receive_sequence_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] preamble_byte,
    input  wire logic [7:0] start_byte,
    input  wire logic [7:0] end_byte,
    input  wire logic [7:0] frame_type,
    input  wire logic [7:0] seq_num,
    input  wire logic [7:0] payload_len,
    input  wire logic [7:0] header_param,
    input  wire logic       crc_ok,
    input  wire logic       history_hit,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      verdict,
    output logic [2:0]      error_code,
    output logic [7:0]      nack_seq,
    output logic            retransmit_request,
    output logic [7:0]      retransmit_seq
);
    import frsc_pkg::*;

    cfg_t   cfg_reg;
    item_t  front_item;
    item_t  q_head;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble <= PREAMBLE_RESET;
            cfg_reg.start_mk <= START_MK_RESET;
            cfg_reg.end_mk   <= END_MK_RESET;
            cfg_reg.max_len  <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PREAMBLE: cfg_reg.preamble <= cfg_data;
                REG_START_MK: cfg_reg.start_mk <= cfg_data;
                REG_END_MK:   cfg_reg.end_mk   <= cfg_data;
                REG_MAX_LEN:  cfg_reg.max_len  <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign in_ready = !q_full;

    frsc_front u_front (
        .cfg           (cfg_reg),
        .preamble_byte (preamble_byte),
        .start_byte    (start_byte),
        .end_byte      (end_byte),
        .frame_type    (frame_type),
        .seq_num       (seq_num),
        .payload_len   (payload_len),
        .header_param  (header_param),
        .crc_ok        (crc_ok),
        .history_hit   (history_hit),
        .item          (front_item)
    );

    frsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    frsc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (q_not_empty),
        .item               (q_head),
        .item_pop           (q_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .verdict            (verdict),
        .error_code         (error_code),
        .nack_seq           (nack_seq),
        .retransmit_request (retransmit_request),
        .retransmit_seq     (retransmit_seq)
    );

`ifndef SYNTHESIS
    a_nack_is_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == V_NACK |-> error_code == E_SEQ)
        else $error("nack verdict without sequence error");

    a_accept_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == V_ACCEPT |-> error_code == E_OK && nack_seq == 8'd0)
        else $error("accept verdict with error code");

    a_rreq_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && retransmit_request |->
            (verdict == V_ACCEPT && error_code == E_OK) ||
            (verdict == V_REJECT && error_code == E_VALUE))
        else $error("retransmit request with wrong verdict");

    a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_not_empty)
        else $error("input stalled with empty queue");
`endif

endmodule

`default_nettype wire

@@ tb/frame_verdict_checker.sv @@
`timescale 1ns / 100ps

module frame_verdict_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] preamble_byte,
    input  wire logic [7:0] start_byte,
    input  wire logic [7:0] end_byte,
    input  wire logic [7:0] frame_type,
    input  wire logic [7:0] seq_num,
    input  wire logic [7:0] payload_len,
    input  wire logic [7:0] header_param,
    input  wire logic       crc_ok,
    input  wire logic       history_hit,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [1:0] verdict,
    input  wire logic [2:0] error_code,
    input  wire logic [7:0] nack_seq,
    input  wire logic       retransmit_request,
    input  wire logic [7:0] retransmit_seq,
    output int              mismatch_count,
    output int              awaited_count
);
    import frsc_pkg::*;

    typedef struct packed {
        logic [7:0] pre;
        logic [7:0] st;
        logic [7:0] en;
        logic [7:0] ftype;
        logic [7:0] seq;
        logic [7:0] len;
        logic [7:0] param;
        logic       crc;
        logic       hit;
    } frame_hdr_t;

    typedef struct packed {
        verdict_t   verdict;
        err_t       code;
        logic [7:0] nack_seq;
        logic       rt_req;
        logic [7:0] rt_seq;
    } frame_verdict_t;

    cfg_t           cfg_shadow;
    logic           sess_open;
    logic [7:0]     sess_total;
    logic [7:0]     sess_next;
    frame_verdict_t awaited_verdicts[$];

    function automatic err_t format_fault(input frame_hdr_t h);
        if (h.pre != cfg_shadow.preamble || h.st != cfg_shadow.start_mk ||
            h.en != cfg_shadow.end_mk)
            return E_VALUE;
        if (h.len > cfg_shadow.max_len)
            return E_LEN;
        if (h.ftype < TYPE_START || h.ftype > TYPE_NACK)
            return E_TYPE;
        if (h.ftype != TYPE_DATA && h.len != 8'd0)
            return E_LEN;
        if (!h.crc)
            return E_CRC;
        return E_OK;
    endfunction

    // Judge one header and advance the session state it implies.
    function automatic frame_verdict_t judge_frame(input frame_hdr_t h);
        frame_verdict_t r;
        r.verdict  = V_REJECT;
        r.code     = format_fault(h);
        r.nack_seq = 8'd0;
        r.rt_req   = 1'b0;
        r.rt_seq   = 8'd0;
        if (r.code == E_OK)
        begin
            if (h.ftype == TYPE_START)
            begin
                if (h.seq != 8'd0)
                begin
                    r.code = E_SEQ;
                end
                else
                begin
                    sess_open  = 1'b1;
                    sess_total = h.param;
                    sess_next  = 8'd1;
                    r.verdict  = V_ACCEPT;
                end
            end
            else if (h.ftype == TYPE_DATA || h.ftype == TYPE_END)
            begin
                if (!sess_open)
                begin
                    r.code = E_NOSTART;
                end
                else if (h.seq != sess_next)
                begin
                    r.code     = E_SEQ;
                    r.verdict  = V_NACK;
                    r.nack_seq = sess_next;
                end
                else if (h.ftype == TYPE_DATA)
                begin
                    sess_next = sess_next + 8'd1;
                    r.verdict = V_ACCEPT;
                end
                else if (sess_total != 8'd0 && h.seq != sess_total - 8'd1)
                begin
                    r.code = E_END;
                end
                else
                begin
                    sess_open  = 1'b0;
                    sess_total = 8'd0;
                    sess_next  = 8'd0;
                    r.verdict  = V_ACCEPT;
                end
            end
            else
            begin
                r.rt_req = 1'b1;
                r.rt_seq = h.param;
                if (h.hit)
                    r.verdict = V_ACCEPT;
                else
                    r.code = E_VALUE;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_verdict_t want;
        frame_hdr_t     hdr;
        if (!rst_n)
        begin
            cfg_shadow.preamble = PREAMBLE_RESET;
            cfg_shadow.start_mk = START_MK_RESET;
            cfg_shadow.end_mk   = END_MK_RESET;
            cfg_shadow.max_len  = MAX_LEN_RESET;
            sess_open           = 1'b0;
            sess_total          = 8'd0;
            sess_next           = 8'd0;
            awaited_verdicts.delete();
            mismatch_count      = 0;
            awaited_count       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PREAMBLE: cfg_shadow.preamble = cfg_data;
                    REG_START_MK: cfg_shadow.start_mk = cfg_data;
                    REG_END_MK:   cfg_shadow.end_mk   = cfg_data;
                    REG_MAX_LEN:  cfg_shadow.max_len  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $error("verdict beat with no header outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    check_field("verdict", 8'(want.verdict), 8'(verdict));
                    check_field("error_code", 8'(want.code), 8'(error_code));
                    check_field("nack_seq", want.nack_seq, nack_seq);
                    check_field("retransmit_request", 8'(want.rt_req), 8'(retransmit_request));
                    check_field("retransmit_seq", want.rt_seq, retransmit_seq);
                end
            end
            if (in_valid && in_ready)
            begin
                hdr = '{preamble_byte, start_byte, end_byte, frame_type, seq_num,
                        payload_len, header_param, crc_ok, history_hit};
                awaited_verdicts.push_back(judge_frame(hdr));
            end
            awaited_count = awaited_verdicts.size();
        end
    end

endmodule

@@ tb/tb_frame_receive_sequence_checker.sv @@
`timescale 1ns / 100ps

module tb_frame_receive_sequence_checker;
    import frsc_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_FRAMES = 305;
    localparam int HOLD_CYCLES  = 150;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] preamble_byte = '0;
    logic [7:0] start_byte = '0;
    logic [7:0] end_byte = '0;
    logic [7:0] frame_type = '0;
    logic [7:0] seq_num = '0;
    logic [7:0] payload_len = '0;
    logic [7:0] header_param = '0;
    logic       crc_ok = 1'b0;
    logic       history_hit = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] verdict;
    logic [2:0] error_code;
    logic [7:0] nack_seq;
    logic       retransmit_request;
    logic [7:0] retransmit_seq;
    int         mismatch_count;
    int         awaited_count;

    logic [7:0] cur_pre = PREAMBLE_RESET;
    logic [7:0] cur_st = START_MK_RESET;
    logic [7:0] cur_en = END_MK_RESET;
    logic [7:0] cur_max = MAX_LEN_RESET;
    int         frames_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    bit         hold_off_req = 1'b0;

    frame_receive_sequence_checker dut (.*);
    frame_verdict_checker checker_i (.*);

    always #2 clk = ~clk;

    // Sender gap after each beat: mostly none or short, now and then long.
    task automatic pace();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (r < 2)
        begin
            burst_left = $urandom_range(10, 30);
            gap = 0;
        end
        else if (r < 55) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(6, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drive_header(input logic [7:0] pre, st, en, typ, seq, len, param,
                                input logic crc, hit);
        preamble_byte <= pre;
        start_byte    <= st;
        end_byte      <= en;
        frame_type    <= typ;
        seq_num       <= seq;
        payload_len   <= len;
        header_param  <= param;
        crc_ok        <= crc;
        history_hit   <= hit;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frames_sent++;
        pace();
    endtask

    task automatic send_good(input logic [7:0] typ, seq, len, param, input logic hit);
        drive_header(cur_pre, cur_st, cur_en, typ, seq, len, param, 1'b1, hit);
    endtask

    // Mostly good markers, otherwise anything goes.
    task automatic send_noise();
        logic [7:0] pre;
        logic [7:0] st;
        logic [7:0] en;
        logic [7:0] typ;
        pre = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_pre;
        st  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_st;
        en  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_en;
        typ = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(TYPE_START, TYPE_NACK));
        drive_header(pre, st, en, typ, 8'($urandom), $urandom_range(0, 1) ? 8'($urandom) : 8'd0,
                     8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic run_session(input int data_frames);
        logic [7:0] nxt;
        logic [7:0] total;
        int         r;
        nxt = 8'd1;
        r = $urandom_range(0, 99);
        if (r < 60) total = 8'(data_frames + 2);
        else if (r < 80) total = 8'd0;
        else total = 8'($urandom);
        send_good(TYPE_START, ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                  8'd0, total, 1'($urandom));
        for (int i = 0; i < data_frames; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
            begin
                send_good(TYPE_DATA, nxt, 8'($urandom_range(0, cur_max)), 8'($urandom),
                          1'($urandom));
                nxt++;
            end
            else if (r < 88)
            begin
                send_good(TYPE_DATA, nxt + 8'($urandom_range(1, 255)), 8'd0, 8'($urandom),
                          1'($urandom));
            end
            else if (r < 94)
            begin
                send_good(TYPE_NACK, 8'($urandom), 8'd0, 8'($urandom), 1'($urandom));
            end
            else
            begin
                send_noise();
            end
        end
        send_good(TYPE_END, ($urandom_range(0, 9) == 0) ? 8'($urandom) : nxt, 8'd0,
                  8'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        int r;
        stop_at = frames_sent + budget;
        while (frames_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 50) run_session($urandom_range(0, 4));
            else if (r < 70) run_session($urandom_range(5, 20));
            else if (r < 75) run_session($urandom_range(21, 60));
            else send_noise();
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] pre, st, en, max_len);
        write_reg(REG_PREAMBLE, pre);
        write_reg(REG_START_MK, st);
        write_reg(REG_END_MK, en);
        // unused index: must leave every register alone
        write_reg(REG_MAX_LEN + 3'($urandom_range(1, 4)), 8'($urandom));
        write_reg(REG_MAX_LEN, max_len);
        cfg_we  <= 1'b0;
        cur_pre = pre;
        cur_st  = st;
        cur_en  = en;
        cur_max = max_len;
    endtask

    // Receiver: random stalls, plus one long hold-off whenever requested.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else if (r < 18)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("tb_frame_receive_sequence_checker: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed headers at the reset settings
        send_good(TYPE_DATA, 8'd1, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_END, 8'd1, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_NACK, 8'd0, 8'd0, 8'hFF, 1'b1);
        send_good(TYPE_NACK, 8'd0, 8'd0, 8'h00, 1'b0);
        send_good(TYPE_START, 8'd5, 8'd0, 8'd3, 1'b0);
        send_good(TYPE_START, 8'd0, 8'd0, 8'd3, 1'b0);
        send_good(TYPE_DATA, 8'd2, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_DATA, 8'd1, MAX_LEN_RESET, 8'd0, 1'b0);
        send_good(TYPE_DATA, 8'd2, MAX_LEN_RESET + 8'd1, 8'd0, 1'b0);
        send_good(TYPE_END, 8'd3, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_END, 8'd2, 8'd0, 8'd0, 1'b0);
        // end count disagrees with the announced total
        send_good(TYPE_START, 8'd0, 8'd0, 8'd2, 1'b0);
        send_good(TYPE_DATA, 8'd1, 8'd1, 8'd0, 1'b0);
        send_good(TYPE_END, 8'd2, 8'd0, 8'd0, 1'b0);
        // restart while open, zero total accepts any end; then one bad marker each
        send_good(TYPE_START, 8'd0, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_END, 8'd1, 8'd0, 8'd0, 1'b0);
        drive_header(8'hAA, cur_st, cur_en, TYPE_DATA, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        drive_header(cur_pre, 8'h00, cur_en, TYPE_DATA, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        drive_header(cur_pre, cur_st, 8'hFF, TYPE_DATA, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        // frame types outside the defined range, then non-data types with a payload length
        send_good(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_good(TYPE_NACK + 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_good(8'hFF, 8'hFF, 8'd0, 8'hFF, 1'b1);
        send_good(TYPE_START, 8'd0, 8'd1, 8'd0, 1'b0);
        send_good(TYPE_NACK, 8'd0, 8'd3, 8'd7, 1'b1);
        // length fault wins over type and CRC faults, then a lone CRC fault
        drive_header(cur_pre, cur_st, cur_en, 8'hFF, 8'd0, 8'd200, 8'd0, 1'b0, 1'b0);
        drive_header(cur_pre, cur_st, cur_en, TYPE_START, 8'd0, 8'd0, 8'd4, 1'b0, 1'b0);

        // one long session of 260 frames between its start and end
        run_session(260);
        run_phase(PHASE_FRAMES - 260);
        wait_idle();

        configure(8'h00, 8'h00, 8'h00, 8'h00);
        hold_off_req = 1'b1;
        burst_left = 80;
        run_phase(PHASE_FRAMES);
        wait_idle();

        configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_phase(PHASE_FRAMES);
        wait_idle();

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 254)));
        hold_off_req = 1'b1;
        burst_left = 80;
        run_phase(PHASE_FRAMES);
        wait_idle();

        configure(PREAMBLE_RESET, START_MK_RESET, END_MK_RESET, 8'($urandom_range(0, 255)));
        run_phase(PHASE_FRAMES);
        wait_idle();

        if (mismatch_count == 0)
            $display("tb_frame_receive_sequence_checker: clean");
        else
            $display("tb_frame_receive_sequence_checker: errors");
        $finish;
    end

endmodule
